// File: sv/enwa_pkg.sv
// ---------------------------------------------------------------------------
// enwa_pkg: shared types and constants
// Register indexes, widths and the controller/datapath command word of the
// edge normalized weighted average filter.
// ---------------------------------------------------------------------------
package enwa_pkg;

	localparam int unsigned MAX_RADIUS_DEF  = 32;
	localparam int unsigned SAMPLE_BITS_DEF = 24;
	localparam int unsigned WEIGHT_BITS     = 16;
	localparam int unsigned TOTAL_BITS      = 22;
	localparam int unsigned RADIUS_BITS     = 6;
	localparam int unsigned ADDR_BITS       = 4;

	// Register byte addresses.
	localparam logic [ADDR_BITS-1:0] REG_RADIUS       = 4'h0;
	localparam logic [ADDR_BITS-1:0] REG_WEIGHT_ADDR  = 4'h4;
	localparam logic [ADDR_BITS-1:0] REG_WEIGHT_VALUE = 4'h8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       shift_in;    // write the accepted word into the window
		logic       clear_acc;   // start a new output
		logic       mac;         // one multiply-accumulate step
		logic       div_start;   // start the divider
		logic [5:0] tap;         // weight index k
		logic [6:0] age;         // sample age, negative when bit 6 is set (valid when mac)
		logic       tap_valid;   // age lies inside the frame
		logic       full;        // window entirely inside frame
		logic       clear_win;   // frame restart
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
	} dp_stat_t;

endpackage

// File: sv/enwa_datapath.sv
// ---------------------------------------------------------------------------
// enwa_datapath: window, weights, MAC and divider
// Holds the sample window as a memory, the weight table, a shared
// multiply-accumulate unit, a weight total sweep and a radix-2 restoring
// divider.
// ---------------------------------------------------------------------------
module enwa_datapath #(
	parameter int unsigned MAX_RADIUS  = enwa_pkg::MAX_RADIUS_DEF,
	parameter int unsigned SAMPLE_BITS = enwa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  enwa_pkg::dp_cmd_t             cmd,
	output enwa_pkg::dp_stat_t            stat,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          wt_we,
	input  logic [5:0]                    wt_addr,
	input  logic [enwa_pkg::WEIGHT_BITS-1:0] wt_data,
	input  logic                          tot_start,
	input  logic [5:0]                    tot_len,
	output logic                          tot_busy,
	output logic [SAMPLE_BITS-1:0]        result
);
	import enwa_pkg::*;

	localparam int unsigned WIN      = 2 * MAX_RADIUS - 1;
	localparam int unsigned ACC_BITS = SAMPLE_BITS + WEIGHT_BITS + 6;
	localparam int unsigned DIV_BITS = ACC_BITS;
	localparam int unsigned CNT_BITS = $clog2(DIV_BITS + 1);

	// Sample window: circular buffer, newest word just above the head.
	logic [SAMPLE_BITS-1:0] win_mem [WIN];
	logic [5:0] head_q;
	logic [WEIGHT_BITS-1:0] wt_mem [WIN];
	logic [WIN-1:0]         wt_vld_q;

	logic [SAMPLE_BITS-1:0] samp_s1;
	logic [WEIGHT_BITS-1:0] wt_raw_s1, wt_s1;
	logic                   wt_vld_s1;
	logic                   use_s1, mac_s1;
	logic [6:0]             rd_idx;
	logic [5:0]             wt_raddr;
	logic signed [ACC_BITS-1:0] acc_q;
	logic [TOTAL_BITS-1:0]  wsum_q;

	logic                   tot_busy_q, trd_s1;
	logic [5:0]             tk_q;
	logic [TOTAL_BITS-1:0]  tsum_q, total_q;

	// Index of the sample of the given age.
	always_comb begin
		logic [6:0] s;
		s = {1'b0, head_q} + cmd.age + 7'd1;
		if (s >= 7'(WIN)) s = s - 7'(WIN);
		rd_idx = s;
	end

	// The weight port serves the total sweep while it runs, else the taps.
	assign wt_raddr = tot_busy_q ? tk_q : cmd.tap;

	// Window and weight memories.
	always_ff @(posedge clk) begin
		if (cmd.shift_in) win_mem[head_q] <= sample;
		if (wt_we && wt_addr < 6'(WIN)) wt_mem[wt_addr[5:0]] <= wt_data;
		samp_s1   <= win_mem[rd_idx[5:0]];
		wt_raw_s1 <= wt_mem[wt_raddr];
	end

	// Weights never written read as zero.
	assign wt_s1 = wt_vld_s1 ? wt_raw_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			use_s1    <= 1'b0;
			mac_s1    <= 1'b0;
			wt_vld_q  <= '0;
			wt_vld_s1 <= 1'b0;
		end else begin
			use_s1 <= cmd.tap_valid;
			mac_s1 <= cmd.mac;
			if (wt_we && wt_addr < 6'(WIN)) wt_vld_q[wt_addr] <= 1'b1;
			wt_vld_s1 <= wt_vld_q[wt_raddr];
			if (cmd.clear_win) head_q <= '0;
			else if (cmd.shift_in) head_q <= (head_q == 6'd0) ? 6'(WIN - 1) : head_q - 6'd1;
		end
	end

	// Weight total: one table read per cycle over the first tot_len entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_busy_q <= 1'b0;
			trd_s1     <= 1'b0;
			tk_q       <= '0;
			tsum_q     <= '0;
			total_q    <= '0;
		end else if (tot_start) begin
			tot_busy_q <= 1'b1;
			trd_s1     <= 1'b0;
			tk_q       <= '0;
			tsum_q     <= '0;
		end else if (tot_busy_q) begin
			trd_s1 <= (tk_q < tot_len);
			if (tk_q < tot_len) tk_q <= tk_q + 6'd1;
			if (trd_s1) tsum_q <= tsum_q + TOTAL_BITS'(wt_s1);
			else if (tk_q >= tot_len) begin
				total_q    <= tsum_q;
				tot_busy_q <= 1'b0;
			end
		end
	end

	assign tot_busy = tot_busy_q;

	// Multiply-accumulate on the registered operands.
	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			acc_q  <= '0;
			wsum_q <= '0;
		end else if (mac_s1 && use_s1) begin
			acc_q  <= acc_q + ACC_BITS'($signed(samp_s1) * $signed({1'b0, wt_s1}));
			wsum_q <= wsum_q + TOTAL_BITS'(wt_s1);
		end
	end

	// Restoring divider on magnitudes, sign fixed at the end.
	logic [DIV_BITS-1:0]   quo_q, rem_q;
	logic [TOTAL_BITS-1:0] dvs_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  neg_q, busy_q, done_q, zero_q;
	logic [DIV_BITS:0]     trial;

	assign trial = {rem_q, quo_q[DIV_BITS-1]} - (DIV_BITS+1)'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.div_start) busy_q <= 1'b1;
			else if (busy_q && cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvs_q  <= cmd.full ? total_q : wsum_q;
			zero_q <= cmd.full ? (total_q == '0) : (wsum_q == '0);
			neg_q  <= acc_q[ACC_BITS-1];
			quo_q  <= acc_q[ACC_BITS-1] ? DIV_BITS'(-acc_q) : DIV_BITS'(acc_q);
			rem_q  <= '0;
			cnt_q  <= CNT_BITS'(DIV_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (!trial[DIV_BITS]) begin
				rem_q <= trial[DIV_BITS-1:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_BITS-2:0], quo_q[DIV_BITS-1]};
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		logic [DIV_BITS-1:0] q;
		q = neg_q ? -quo_q : quo_q;
		result = zero_q ? '0 : q[SAMPLE_BITS-1:0];
	end

	assign stat.div_busy = busy_q;
	assign stat.div_done = done_q;

endmodule

// File: sv/enwa_control.sv
// ---------------------------------------------------------------------------
// enwa_control: sequencing state machine
// Accepts a word, walks the window taps for each due output, starts the
// divider and hands results to the output register.
// ---------------------------------------------------------------------------
module enwa_control #(
	parameter int unsigned MAX_RADIUS = enwa_pkg::MAX_RADIUS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [5:0]        radius,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_free,
	output logic              out_load,
	output logic              out_last,
	output enwa_pkg::dp_cmd_t cmd,
	input  enwa_pkg::dp_stat_t stat
);
	import enwa_pkg::*;

	localparam int unsigned WIN = 2 * MAX_RADIUS - 1;

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_DIV, S_WAIT, S_OUT} state_t;

	state_t     state_q;
	logic [5:0] cnt_q, r_q, c_q, k_q;
	logic       last_q, full_q;
	logic [6:0] age;
	logic [5:0] reff;

	assign reff = (radius == 6'd0) ? 6'd1 : (radius > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : radius;
	// Age of tap k: c + r - 1 - k, negative flagged by bit 6.
	assign age = 7'(c_q) + 7'(r_q) - 7'd1 - 7'(k_q);

	always_comb begin
		cmd = '0;
		cmd.tap = k_q;
		cmd.age = age;
		cmd.full = full_q;
		in_ready = (state_q == S_IDLE);
		cmd.shift_in = in_valid && in_ready;
		if (state_q == S_MAC) begin
			cmd.mac = 1'b1;
			cmd.tap_valid = !age[6] && (age < 7'(cnt_q));
		end
		// The accumulator clears on the first tap of each output.
		cmd.clear_acc = (state_q == S_MAC) && k_q == 6'd0;
		cmd.div_start = (state_q == S_DIV);
		cmd.clear_win = (state_q == S_OUT) && out_free && last_q && c_q == 6'd0;
	end

	assign out_load = (state_q == S_OUT) && out_free;
	assign out_last = last_q && c_q == 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0; r_q <= 6'd1; c_q <= '0; k_q <= '0;
			last_q <= 1'b0; full_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					logic [5:0] n;
					n = (cnt_q == 6'(WIN)) ? cnt_q : cnt_q + 6'd1;
					cnt_q <= n; r_q <= reff; last_q <= in_last; k_q <= '0;
					if (in_last) begin
						// Flush from the oldest pending center down to age 0.
						if (reff - 6'd1 < n) c_q <= reff - 6'd1; else c_q <= n - 6'd1;
						state_q <= S_MAC;
					end else if (reff - 6'd1 < n) begin
						c_q <= reff - 6'd1;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (age[6] || age >= 7'(cnt_q)) full_q <= 1'b0;
					if (k_q == 6'd0) full_q <= !(age[6] || age >= 7'(cnt_q));
					if (k_q == {r_q[4:0], 1'b0} - 6'd2) state_q <= S_DRAIN;
					else k_q <= k_q + 6'd1;
				end
				S_DRAIN: state_q <= S_DIV;
				S_DIV: state_q <= S_WAIT;
				S_WAIT: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (out_free) begin
					k_q <= '0;
					if (last_q && c_q != 6'd0) begin
						c_q <= c_q - 6'd1;
						state_q <= S_MAC;
					end else begin
						if (last_q) cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/edge_normalized_weighted_average.sv
// ---------------------------------------------------------------------------
// edge_normalized_weighted_average: edge-renormalized smoothing filter
// Streams a frame of samples and emits weighted window averages.
// ---------------------------------------------------------------------------
// channel | dir | handshake         | payload
// s_axis  | in  | tvalid/tready     | tdata: sample; tuser: frame_end
// m_axis  | out | tvalid/tready     | tdata: smoothed; tuser: run_last
// apb     | in  | psel/penable      | radius, weight_addr, weight_value
// Each output runs through 2R-1 taps on the shared multiplier, a drain, a
// divider load, 46 quotient steps, a wait for the divider to finish and an
// output step.
// Input is taken one word at a time while the controller is idle.
// A held output word does not stop the next input from being accepted.
// A radius or weight write starts a total sweep that holds input.
// Reset clears the window position and counts, sets the radius to 1 and makes the weights read as 0 until written.
module edge_normalized_weighted_average #(
	parameter int unsigned MAX_RADIUS  = enwa_pkg::MAX_RADIUS_DEF,
	parameter int unsigned SAMPLE_BITS = enwa_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // [SAMPLE_BITS-1:0] sample
	input  logic        s_axis_tuser,                       // [0] frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // [SAMPLE_BITS-1:0] smoothed
	output logic        m_axis_tuser,                       // [0] run_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [enwa_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import enwa_pkg::*;

	localparam int unsigned DW  = ((SAMPLE_BITS + 7) / 8) * 8;

	logic [5:0]  radius_q, waddr_q;
	logic [15:0] wval_q;
	logic        wr, tot_start, tot_busy;
	logic [5:0]  reff_cfg, tot_len;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 6'd1; waddr_q <= '0; wval_q <= '0;
		end else if (wr) begin
			unique case (paddr)
				REG_RADIUS: radius_q <= pwdata[5:0];
				REG_WEIGHT_ADDR: waddr_q <= pwdata[5:0];
				REG_WEIGHT_VALUE: wval_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// A radius or weight write restarts the weight total sweep over 2R-1 taps.
	assign tot_start = wr && (paddr == REG_RADIUS || paddr == REG_WEIGHT_VALUE);
	assign reff_cfg  = (radius_q == 6'd0) ? 6'd1 :
		(radius_q > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : radius_q;
	assign tot_len   = {reff_cfg[4:0], 1'b0} - 6'd1;

	always_comb begin
		unique case (paddr)
			REG_RADIUS:       prdata = {26'd0, radius_q};
			REG_WEIGHT_ADDR:  prdata = {26'd0, waddr_q};
			REG_WEIGHT_VALUE: prdata = {16'd0, wval_q};
			default:          prdata = '0;
		endcase
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [SAMPLE_BITS-1:0] result;
	logic out_load, out_last, ctl_ready;
	logic ovalid_q, olast_q;
	logic [SAMPLE_BITS-1:0] odata_q;

	enwa_control #(.MAX_RADIUS(MAX_RADIUS)) u_ctl (
		.clk, .arst_n, .radius(radius_q),
		.in_valid(s_axis_tvalid && !tot_busy), .in_last(s_axis_tuser), .in_ready(ctl_ready),
		.out_free(!ovalid_q || m_axis_tready), .out_load, .out_last,
		.cmd, .stat
	);

	enwa_datapath #(.MAX_RADIUS(MAX_RADIUS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .sample(s_axis_tdata[SAMPLE_BITS-1:0]),
		.wt_we(wr && paddr == REG_WEIGHT_VALUE), .wt_addr(waddr_q),
		.wt_data(pwdata[15:0]), .tot_start, .tot_len, .tot_busy, .result
	);

	assign s_axis_tready = ctl_ready && !tot_busy;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (out_load) ovalid_q <= 1'b1;
		else if (m_axis_tready) ovalid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= result;
			olast_q <= out_last;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = DW'(odata_q);
	assign m_axis_tuser  = olast_q;

endmodule

// File: sv/enwa_checker.sv
// ---------------------------------------------------------------------------
// enwa_checker: port-level checks
// Watches the stream and register ports of the filter.
// ---------------------------------------------------------------------------
module enwa_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tuser,
	input logic pready
);
	// A stalled output word stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");

	// The register port never stalls.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

	// A stalled output word keeps its frame marker.
	a_last_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tuser))
		else $error("run_last changed while stalled");
endmodule

bind edge_normalized_weighted_average enwa_checker u_chk (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
	.m_axis_tready, .m_axis_tuser, .pready
);

// File: sim/edge_normalized_weighted_average_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// edge_normalized_weighted_average_test: self-checking bench for the filter
// Streams frames of samples through the smoothing filter under varying
// radius and weight settings and random stalls on both stream sides. Every
// output word is checked against a cycle-free model of the edge-renormalized
// weighted average that is kept in step with the APB writes.
// ---------------------------------------------------------------------------
module edge_normalized_weighted_average_test;
	import enwa_pkg::*;

	localparam int WIN = 63;
	localparam int NUM_ITEMS = 420;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic signed [23:0] smoothed;
		logic               run_last;
	} avg_word_t;

	typedef enum {SET_NONE, SET_WIDE_TAPS, SET_UNIT_RADIUS, SET_MAX_RADIUS, SET_NARROW}
		setup_t;

	typedef struct {
		setup_t             setup;
		logic signed [23:0] sample;
		logic               frame_end;
		logic               typed;
		avg_word_t          typed_word;
	} row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [23:0] sample
	logic        s_axis_tuser = 0;    // [0] frame_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;        // [23:0] smoothed
	logic        m_axis_tuser;        // [0] run_last
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	edge_normalized_weighted_average uut (.*);

	// Model state of the filter.
	logic [15:0]        taps [WIN];
	logic signed [23:0] history [WIN];
	int unsigned        seen_count;
	logic [21:0]        tap_sum;
	logic [5:0]         radius_reg, waddr_reg;

	avg_word_t averages_due[$];
	int        mismatches = 0;
	int        send_idle = 0, recv_idle = 0;
	bit        hold_req = 0;
	bit        hold_done = 0;
	int        hold_cnt = 0;
	int        quiet_cycles = 0;
	bit        cur_typed = 0;
	avg_word_t cur_word;

	initial forever #5 clk = ~clk;

	function automatic int unsigned active_radius();
		if (radius_reg < 1) return 1;
		if (radius_reg > 32) return 32;
		return radius_reg;
	endfunction

	function automatic void refresh_sum();
		int unsigned t = 0;
		for (int k = 0; k < 2 * active_radius() - 1; k++) t += taps[k];
		tap_sum = t[21:0];
	endfunction

	function automatic logic signed [23:0] window_average(int c, int r, int cnt);
		longint acc = 0;
		longint wsum = 0;
		bit     full = 1;
		int     age;
		for (int k = 0; k < 2 * r - 1; k++) begin
			age = c + r - 1 - k;
			if (age < 0 || age >= cnt) begin
				full = 0;
				continue;
			end
			acc += longint'(history[age]) * longint'({1'b0, taps[k]});
			wsum += longint'({1'b0, taps[k]});
		end
		if (full) wsum = longint'({1'b0, tap_sum});
		if (wsum == 0) return '0;
		acc = acc / wsum;
		return acc[23:0];
	endfunction

	// Advance the model by one accepted word and queue the averages it yields.
	function automatic void predict_word(logic signed [23:0] smp, logic fend);
		int unsigned r = active_radius();
		avg_word_t w;
		for (int i = WIN - 1; i > 0; i--) history[i] = history[i - 1];
		history[0] = smp;
		if (seen_count < WIN) seen_count++;
		if (!fend) begin
			if (r - 1 < seen_count) begin
				w.smoothed = window_average(r - 1, r, seen_count);
				w.run_last = 0;
				averages_due.push_back(w);
			end
			return;
		end
		for (int c = r - 1; c >= 0; c--) begin
			if (c < seen_count) begin
				w.smoothed = window_average(c, r, seen_count);
				w.run_last = (c == 0);
				averages_due.push_back(w);
			end
		end
		seen_count = 0;
		for (int i = 0; i < WIN; i++) history[i] = '0;
	endfunction

	function automatic void model_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
		case (addr)
			REG_RADIUS: begin
				radius_reg = data[5:0];
				refresh_sum();
			end
			REG_WEIGHT_ADDR: waddr_reg = data[5:0];
			REG_WEIGHT_VALUE: begin
				if (waddr_reg < WIN) begin
					taps[waddr_reg] = data[15:0];
					refresh_sum();
				end
			end
			default: ;
		endcase
	endfunction

	// Sample all handshakes at the rising edge.
	always @(posedge clk) begin
		avg_word_t got, want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) model_write(paddr, pwdata);
			if (s_axis_tvalid && s_axis_tready) begin
				if (cur_typed) begin
					predict_word(s_axis_tdata, s_axis_tuser);
					void'(averages_due.pop_back());
					averages_due.push_back(cur_word);
				end else begin
					predict_word(s_axis_tdata, s_axis_tuser);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.smoothed = m_axis_tdata;
				got.run_last = m_axis_tuser;
				if (averages_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: smoothed=%0d run_last=%0b",
							got.smoothed, got.run_last);
				end else begin
					want = averages_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: smoothed exp %0d got %0d, run_last exp %0b got %0b",
								want.smoothed, got.smoothed, want.run_last, got.run_last);
					end
				end
			end
			// Watchdog on cycles without any transfer.
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Output side: random back-pressure plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 2000;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic reg_write(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_tap(int addr, logic [15:0] val);
		reg_write(REG_WEIGHT_ADDR, addr);
		reg_write(REG_WEIGHT_VALUE, {16'd0, val});
	endtask

	// Offer one word and hold it until it is taken.
	task automatic push_sample(logic signed [23:0] smp, logic fend, bit typed, avg_word_t tw);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= smp;
		s_axis_tuser <= fend;
		cur_typed = typed;
		cur_word = tw;
		// Ready only moves at rising edges, so the value between edges decides.
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
	endtask

	// Let the block go idle: all averages in, then a margin for work in flight.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 0;
		while (averages_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setup(setup_t s);
		settle();
		case (s)
			SET_WIDE_TAPS: begin
				reg_write(REG_RADIUS, 3);
				set_tap(0, 16'hFFFF);
				set_tap(1, 16'd1000);
				set_tap(2, 16'h8000);
				set_tap(3, 16'd0);
				set_tap(4, 16'd2000);
			end
			SET_UNIT_RADIUS: begin
				set_tap(63, 16'hFFFF);    // out of range, ignored
				set_tap(0, 16'd0);        // zero divisor
				reg_write(REG_RADIUS, 0);
			end
			SET_MAX_RADIUS: begin
				for (int k = 0; k < WIN; k++) set_tap(k, 16'hFFFF);
				reg_write(REG_RADIUS, 63);
			end
			SET_NARROW: reg_write(REG_RADIUS, 2);
			default: ;
		endcase
	endtask

	function automatic row_t mk(setup_t s, int smp, bit fend, bit typed = 0);
		row_t r;
		r.setup = s;
		r.sample = 24'(smp);
		r.frame_end = fend;
		r.typed = typed;
		r.typed_word.smoothed = '0;
		r.typed_word.run_last = fend;
		return r;
	endfunction

	initial begin
		row_t rows[$];
		avg_word_t none;
		int sent = 0;
		int r, flen;
		logic [15:0] wv;
		none = '0;
		for (int i = 0; i < WIN; i++) begin
			taps[i] = '0;
			history[i] = '0;
		end
		seen_count = 0;
		tap_sum = '0;
		radius_reg = 1;
		waddr_reg = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Reset weights are zero, so every average is zero.
		rows.push_back(mk(SET_NONE, 0, 0, 1));
		rows.push_back(mk(SET_NONE, 8388607, 0, 1));
		rows.push_back(mk(SET_NONE, -8388608, 0, 1));
		rows.push_back(mk(SET_NONE, -1, 1, 1));
		rows.push_back(mk(SET_NONE, 1, 1, 1));
		// Short frame, then a full frame with extreme samples.
		rows.push_back(mk(SET_WIDE_TAPS, 100, 0));
		rows.push_back(mk(SET_NONE, -8388608, 1));
		rows.push_back(mk(SET_NONE, 8388607, 0));
		rows.push_back(mk(SET_NONE, -8388608, 0));
		rows.push_back(mk(SET_NONE, 12345, 0));
		rows.push_back(mk(SET_NONE, -7, 0));
		rows.push_back(mk(SET_NONE, 8388607, 0));
		rows.push_back(mk(SET_NONE, 8388607, 0));
		rows.push_back(mk(SET_NONE, 0, 1));
		// Radius zero acts as one, with a zero center weight.
		rows.push_back(mk(SET_UNIT_RADIUS, 5000, 0));
		rows.push_back(mk(SET_NONE, -5000, 1));
		// Radius above range acts as the maximum; short frame at full weights.
		rows.push_back(mk(SET_MAX_RADIUS, 8388607, 0));
		rows.push_back(mk(SET_NONE, -8388608, 0));
		rows.push_back(mk(SET_NONE, 8388607, 1));
		rows.push_back(mk(SET_NONE, 3, 0));
		// Radius changed while a frame is open.
		rows.push_back(mk(SET_NARROW, 4, 0));
		rows.push_back(mk(SET_NONE, 9, 1));

		send_idle = 9;
		recv_idle = 53;
		foreach (rows[i]) begin
			if (rows[i].setup != SET_NONE) apply_setup(rows[i].setup);
			push_sample(rows[i].sample, rows[i].frame_end, rows[i].typed, rows[i].typed_word);
		end

		// Random phases: new settings, then a few frames, some left open.
		while (sent < NUM_ITEMS) begin
			settle();
			if (sent < NUM_ITEMS / 3) begin
				send_idle = 9;
				recv_idle = 53;
			end else if (sent < 2 * NUM_ITEMS / 3) begin
				send_idle = 53;
				recv_idle = 9;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case ($urandom_range(19))
				0: r = 32;
				1: r = 63;
				2: r = 0;
				3, 4: r = $urandom_range(5, 12);
				default: r = $urandom_range(1, 4);
			endcase
			reg_write(REG_RADIUS, r);
			if (r < 1) r = 1;
			if (r > 32) r = 32;
			for (int k = 0; k < 2 * r - 1; k++) begin
				case ($urandom_range(9))
					0: wv = 16'd0;
					1: wv = 16'hFFFF;
					default: wv = 16'($urandom_range(65535));
				endcase
				set_tap(k, wv);
			end
			if ($urandom_range(4) == 0) set_tap($urandom_range(63), 16'($urandom_range(65535)));
			// One long receiver hold-off while the sender keeps offering words.
			if (sent >= 2 * NUM_ITEMS / 3 && !hold_done) begin
				hold_req = 1;
				hold_done = 1;
			end
			for (int f = $urandom_range(1, 3); f > 0; f--) begin
				if (r <= 4 && $urandom_range(9) == 0) flen = 70;
				else flen = $urandom_range(1, 2 * r + 4);
				for (int j = 0; j < flen; j++) begin
					push_sample(24'($urandom), (j == flen - 1) && ($urandom_range(9) != 0),
						0, none);
					sent++;
				end
			end
		end

		settle();
		if (averages_due.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
